>>> rtl/ero_pkg.sv
// ============================================================================
// Epicycle oscillator package
// Shared types, register codes and helper functions of the oscillator node.
// ============================================================================
package ero_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int COEF_W      = 16;
    localparam int SUM_W       = 20;
    localparam int TURN_W      = 32;
    localparam int MID_DEPTH   = 2;
    localparam int OUT_DEPTH   = 16;
    localparam int OCC_W       = $clog2(OUT_DEPTH + 1);
    localparam int PIPE_STAGES = 7;
    localparam int NUM_COEFS   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_TARGET = 3'd0,
        REG_START_PHASE = 3'd1,
        REG_COEF_XC     = 3'd2,
        REG_COEF_XS     = 3'd3,
        REG_COEF_YC     = 3'd4,
        REG_COEF_YS     = 3'd5,
        REG_COEF_ZC     = 3'd6,
        REG_COEF_ZS     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [TURN_W-1:0] turn;
        vec_t              sum;
    } item_t;

    localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [16:0] POLY_C1 = 17'd102944;
    localparam logic [15:0] POLY_C3 = 16'd42048;
    localparam logic [12:0] POLY_C5 = 13'd4640;
    localparam logic [16:0] MAG_MAX = 17'd32767;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 20'sh7FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 20'sh80000;

    // Folds a turn into the first quadrant and returns the Q16 argument.
    function automatic logic [16:0] fold_u(input logic [TURN_W-1:0] t);
        logic [30:0] frac;
        begin
            frac = {1'b0, t[29:0]};
            if (t[30])
            begin
                frac = 31'h4000_0000 - frac;
            end
            return frac[30:14];
        end
    endfunction

    // Clamps a widened sum to the signed output range.
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        begin
            if (v[SUM_W] != v[SUM_W-1])
            begin
                r = v[SUM_W] ? SUM_MIN : SUM_MAX;
            end
            else
            begin
                r = v[SUM_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/ero_fifo.sv
// ============================================================================
// Register queue
// Small first-in first-out queue built from flip-flops, head read directly.
// ============================================================================
module ero_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/ero_front.sv
// ============================================================================
// Oscillator front end
// Accepts a transaction, advances the smoothed step and the phase, and
// queues the phase turn with the incoming running sum for the back end.
// ============================================================================
module ero_front #(
    parameter int PHASE_BITS = 24,
    parameter int CFG_W      = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic signed [ero_pkg::SUM_W-1:0]   in_x,
    input  logic signed [ero_pkg::SUM_W-1:0]   in_y,
    input  logic signed [ero_pkg::SUM_W-1:0]   in_z,
    input  logic                               wr_en,
    input  logic [ero_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [CFG_W-1:0]                   wr_data,
    input  logic                               mid_full,
    output logic                               mid_push,
    output ero_pkg::item_t                     mid_item
);

    import ero_pkg::*;

    logic [PHASE_BITS-1:0] step_target_reg, step_target_next;
    logic [PHASE_BITS-1:0] step_now_reg, step_now_next;
    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_BITS:0]   step_sum;
    logic [PHASE_BITS-1:0] step_new;
    logic [PHASE_BITS-1:0] phase_new;
    logic                  accept;

    assign accept    = push && !mid_full;
    assign step_sum  = {1'b0, step_now_reg} + {1'b0, step_target_reg};
    assign step_new  = step_sum[PHASE_BITS:1];
    assign phase_new = phase_acc_reg + step_new;

    assign mid_push     = accept;
    assign mid_item.turn = TURN_W'(phase_new) << (TURN_W - PHASE_BITS);
    assign mid_item.sum.x = in_x;
    assign mid_item.sum.y = in_y;
    assign mid_item.sum.z = in_z;

    always_comb
    begin
        step_target_next = step_target_reg;
        step_now_next    = step_now_reg;
        phase_acc_next   = phase_acc_reg;
        if (accept)
        begin
            step_now_next  = step_new;
            phase_acc_next = phase_new;
        end
        if (wr_en && (wr_index == REG_STEP_TARGET))
        begin
            step_target_next = wr_data[PHASE_BITS-1:0];
        end
        if (wr_en && (wr_index == REG_START_PHASE))
        begin
            phase_acc_next = wr_data[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_target_reg <= '0;
            step_now_reg    <= '0;
            phase_acc_reg   <= '0;
        end
        else
        begin
            step_target_reg <= step_target_next;
            step_now_reg    <= step_now_next;
            phase_acc_reg   <= phase_acc_next;
        end
    end

endmodule

>>> rtl/ero_back.sv
// ============================================================================
// Oscillator back end
// Pipelined sine and cosine evaluation, rotation into 3D and saturating
// accumulation. Issues only when the result queue has a slot reserved.
// ============================================================================
module ero_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [ero_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [ero_pkg::COEF_W-1:0]      wr_data,
    input  logic                            mid_empty,
    input  ero_pkg::item_t                  mid_item,
    output logic                            mid_pop,
    input  logic                            out_pop,
    output logic                            res_push,
    output ero_pkg::vec_t                   res_data
);

    import ero_pkg::*;

    logic signed [COEF_W-1:0] coef_reg [NUM_COEFS];
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic                     issue;
    logic                     valid_reg [PIPE_STAGES];
    vec_t                     sum_reg [PIPE_STAGES];

    logic [TURN_W-1:0]        lane_turn [2];
    logic [16:0]              lane_u [2];
    logic [33:0]              sq_prod [2];
    logic [29:0]              c5_prod [2];
    logic [32:0]              c3_prod [2];
    logic [33:0]              c1_prod [2];
    logic [17:0]              mag_sum [2];
    logic [16:0]              mag_raw [2];
    logic [15:0]              mag_clip [2];

    logic                     neg_reg [4][2];
    logic [16:0]              u_reg [3][2];
    logic [16:0]              u2_reg [2][2];
    logic [15:0]              r1_reg [2];
    logic [16:0]              r2_reg [2];
    logic [16:0]              r3_reg [2];
    logic signed [15:0]       sc_reg [2];
    logic signed [31:0]       pc_reg [3];
    logic signed [31:0]       ps_reg [3];
    logic signed [17:0]       rot_reg [3];
    logic [32:0]              rot_sum [3];
    logic [SUM_W:0]           tot [3];

    assign issue   = !mid_empty && (occ_reg < OCC_W'(OUT_DEPTH));
    assign mid_pop = issue;

    always_comb
    begin
        occ_next = occ_reg;
        if (issue && !out_pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (out_pop && !issue)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            for (int i = 0; i < PIPE_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            occ_reg      <= occ_next;
            valid_reg[0] <= issue;
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                if (wr_en && (wr_index == CFG_IDX_W'(int'(REG_COEF_XC) + i)))
                begin
                    coef_reg[i] <= wr_data;
                end
            end
        end
    end

    // Lane 0 evaluates the sine, lane 1 the cosine.
    always_comb
    begin
        lane_turn[0] = mid_item.turn;
        lane_turn[1] = mid_item.turn + QUARTER_TURN;
        for (int l = 0; l < 2; l++)
        begin
            lane_u[l]   = fold_u(lane_turn[l]);
            sq_prod[l]  = 34'(lane_u[l]) * 34'(lane_u[l]);
            c5_prod[l]  = 30'(u2_reg[0][l]) * 30'(POLY_C5);
            c3_prod[l]  = 33'(u2_reg[1][l]) * 33'(r1_reg[l]);
            c1_prod[l]  = 34'(u_reg[2][l]) * 34'(r2_reg[l]);
            mag_sum[l]  = 18'(r3_reg[l]) + 18'd1;
            mag_raw[l]  = mag_sum[l][17:1];
            mag_clip[l] = (mag_raw[l] > MAG_MAX) ? MAG_MAX[15:0] : mag_raw[l][15:0];
        end
        for (int k = 0; k < 3; k++)
        begin
            rot_sum[k] = {pc_reg[k][31], pc_reg[k]} + {ps_reg[k][31], ps_reg[k]};
        end
        tot[0] = {sum_reg[6].x[SUM_W-1], sum_reg[6].x} + (SUM_W+1)'(rot_reg[0]);
        tot[1] = {sum_reg[6].y[SUM_W-1], sum_reg[6].y} + (SUM_W+1)'(rot_reg[1]);
        tot[2] = {sum_reg[6].z[SUM_W-1], sum_reg[6].z} + (SUM_W+1)'(rot_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        sum_reg[0] <= mid_item.sum;
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            sum_reg[i] <= sum_reg[i-1];
        end
        for (int l = 0; l < 2; l++)
        begin
            neg_reg[0][l] <= lane_turn[l][31];
            u_reg[0][l]   <= lane_u[l];
            u2_reg[0][l]  <= sq_prod[l][32:16];
            neg_reg[1][l] <= neg_reg[0][l];
            u_reg[1][l]   <= u_reg[0][l];
            u2_reg[1][l]  <= u2_reg[0][l];
            r1_reg[l]     <= POLY_C3 - {2'b00, c5_prod[l][29:16]};
            neg_reg[2][l] <= neg_reg[1][l];
            u_reg[2][l]   <= u_reg[1][l];
            r2_reg[l]     <= POLY_C1 - c3_prod[l][32:16];
            neg_reg[3][l] <= neg_reg[2][l];
            r3_reg[l]     <= c1_prod[l][32:16];
            sc_reg[l]     <= neg_reg[3][l] ? -signed'(mag_clip[l]) : signed'(mag_clip[l]);
        end
        for (int k = 0; k < 3; k++)
        begin
            pc_reg[k]  <= coef_reg[2*k] * sc_reg[1];
            ps_reg[k]  <= coef_reg[2*k+1] * sc_reg[0];
            rot_reg[k] <= rot_sum[k][32:15];
        end
    end

    assign res_push   = valid_reg[PIPE_STAGES-1];
    assign res_data.x = sat_sum(tot[0]);
    assign res_data.y = sat_sum(tot[1]);
    assign res_data.z = sat_sum(tot[2]);

endmodule

>>> rtl/epicycle_rotated_oscillator_unit.sv
// ============================================================================
// Epicycle rotated oscillator unit
// One node of an epicycle chain: phase synthesis, sine and cosine, rotation
// into 3D and saturating addition to the incoming running sum.
// ============================================================================
// A result passes through the middle queue, the back-end pipeline and the result queue.
// Throughput: one transaction per cycle unless a full queue holds the flow, set by the
// seven-stage back-end pipeline and a sixteen-entry result queue with slot reservation.
// Reset clears the phase, both steps, the coefficients, the valid bits and both queues.
module epicycle_rotated_oscillator_unit #(
    parameter int PHASE_BITS = 24
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          push,
    output logic                                          full,
    input  logic signed [ero_pkg::SUM_W-1:0]              in_x,
    input  logic signed [ero_pkg::SUM_W-1:0]              in_y,
    input  logic signed [ero_pkg::SUM_W-1:0]              in_z,
    output logic                                          empty,
    input  logic                                          pop,
    output logic signed [ero_pkg::SUM_W-1:0]              out_x,
    output logic signed [ero_pkg::SUM_W-1:0]              out_y,
    output logic signed [ero_pkg::SUM_W-1:0]              out_z,
    input  logic                                          wr_en,
    input  logic [ero_pkg::CFG_IDX_W-1:0]                 wr_index,
    input  logic [((PHASE_BITS > 16) ? PHASE_BITS : 16)-1:0] wr_data
);

    import ero_pkg::*;

    localparam int CFG_W = (PHASE_BITS > 16) ? PHASE_BITS : 16;

    item_t mid_in_item;
    item_t mid_out_item;
    logic  mid_push;
    logic  mid_pop;
    logic  mid_empty;
    logic  res_push;
    vec_t  res_data;
    vec_t  out_data;
    logic  out_pop;

    assign out_pop = pop && !empty;
    assign out_x   = out_data.x;
    assign out_y   = out_data.y;
    assign out_z   = out_data.z;

    ero_front #(
        .PHASE_BITS (PHASE_BITS),
        .CFG_W      (CFG_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_x     (in_x),
        .in_y     (in_y),
        .in_z     (in_z),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .mid_full (full),
        .mid_push (mid_push),
        .mid_item (mid_in_item)
    );

    ero_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_in_item),
        .full    (full),
        .pop     (mid_pop),
        .rd_data (mid_out_item),
        .empty   (mid_empty)
    );

    ero_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data[COEF_W-1:0]),
        .mid_empty (mid_empty),
        .mid_item  (mid_out_item),
        .mid_pop   (mid_pop),
        .out_pop   (out_pop),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // The back end reserves a slot before issuing, so this queue never overflows.
    ero_fifo #(
        .WIDTH ($bits(vec_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_data),
        .full    (),
        .pop     (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

endmodule
